FILE: rtl/verlet_step_with_sphere_bound_macros.svh
// Assertion macros used by the checker file of the Verlet step block.
// No dependencies; included by the checker module only.
`ifndef VERLET_STEP_WITH_SPHERE_BOUND_MACROS_SVH
`define VERLET_STEP_WITH_SPHERE_BOUND_MACROS_SVH

// Property checked outside reset.
`define VSB_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked at every edge, reset included.
`define VSB_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/vsb_pkg.sv
// Types, constants and helpers for the Verlet step with sphere bound.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package vsb_pkg;

   localparam int FRAC_BITS = 16;
   localparam int COORD_W = 32;
   localparam int LIM_W = 31;
   localparam int AXES = 3;
   localparam int SQRT_STAGES = 32;
   localparam int DIV_STAGES = 31;

   localparam logic [31:0] DT_SQ_RESET = 32'd1193046;
   localparam logic [LIM_W-1:0] RADIUS_RESET = LIM_W'(100 << FRAC_BITS);

   localparam logic signed [COORD_W-1:0] COORD_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [COORD_W-1:0] COORD_MIN = 32'sh8000_0000;

   typedef enum logic [1:0] {
      CSR_DT_SQUARED       = 2'd0,
      CSR_CONTAINER_RADIUS = 2'd1,
      CSR_BOUND_ENABLE     = 2'd2
   } csr_index_type;

   typedef logic signed [COORD_W-1:0] coord_type;

   typedef struct packed {
      coord_type          cur_x;
      coord_type          cur_y;
      coord_type          cur_z;
      coord_type          prev_x;
      coord_type          prev_y;
      coord_type          prev_z;
      coord_type          acc_x;
      coord_type          acc_y;
      coord_type          acc_z;
      logic [LIM_W-1:0]   particle_radius;
   } req_payload_type;

   typedef struct packed {
      coord_type next_x;
      coord_type next_y;
      coord_type next_z;
      coord_type vel_x;
      coord_type vel_y;
      coord_type vel_z;
      logic      was_clamped;
      logic      saturated;
   } rsp_payload_type;

   // What travels alongside the bound arithmetic.
   typedef struct packed {
      coord_type [AXES-1:0] pos;
      coord_type [AXES-1:0] vel;
      logic                 sat;
      logic                 clamp;
      logic [LIM_W-1:0]     lim;
   } side_type;

   function automatic logic [COORD_W-1:0] mag32(input coord_type p);
      logic [COORD_W-1:0] r;
      r = p[COORD_W-1] ? (~p + 32'd1) : p;
      return r;
   endfunction

endpackage

FILE: rtl/vsb_chan_if.sv
// Valid/ready channel carrying one item of a given payload type.
// Depends on nothing; payload types come from vsb_pkg at instantiation.
`timescale 1ns / 1ps

interface vsb_chan_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/verlet_step_with_sphere_bound.sv
// Channel   | Dir | Payload
// req_chan  | in  | current, previous position, acceleration, particle radius
// rsp_chan  | out | next position, velocity, was_clamped, saturated
// csr_*     | in  | write enable, register index, 32-bit data
//
// One particle enters per cycle unless the output stalls; between acceptance
// and result lie 2 integrate stages, 3 for squares and bound test, 32 for the
// square root, 1 for the scale product, 31 for the divider and then the output
// register. All stages advance together whenever the output register is empty
// or being taken, so a stall holds every stage in place. Reset is synchronous
// and clears the valid bits and loads the configuration registers' defaults.
`timescale 1ns / 1ps

module verlet_step_with_sphere_bound
   import vsb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   vsb_chan_if.sink    req_chan,
   vsb_chan_if.source  rsp_chan,
   input  logic        csr_we,
   input  logic [1:0]  csr_addr,
   input  logic [31:0] csr_wdata
);

   logic [31:0]      dt_squared_ff;
   logic [LIM_W-1:0] container_radius_ff;
   logic             bound_enable_ff;

   logic             adv;
   logic             int_valid;
   side_type         int_side;

   logic [63:0]      sq3_ff [AXES];
   logic [61:0]      mm3_ff;
   side_type         side3_ff;
   logic             vld3_ff;

   logic [63:0]      rad4_ff;
   logic [61:0]      mm4_ff;
   side_type         side4_ff;
   logic             vld4_ff;

   side_type         side5_in;
   logic [63:0]      rad5_ff;
   side_type         side5_ff;
   logic             vld5_ff;

   logic             sq_valid;
   logic [31:0]      sq_root;
   side_type         sq_side;

   logic [62:0]      num_ff [AXES];
   logic [31:0]      den_ff;
   side_type         side6_ff;
   logic             vld6_ff;

   logic             dv_valid;
   logic [LIM_W-1:0] dv_quo [AXES];
   side_type         dv_side;

   rsp_payload_type  rsp_in;
   rsp_payload_type  rsp_data_ff;
   logic             rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         dt_squared_ff <= DT_SQ_RESET;
         container_radius_ff <= RADIUS_RESET;
         bound_enable_ff <= 1'b1;
      end else if (csr_we) begin
         if (csr_addr == CSR_DT_SQUARED) begin
            dt_squared_ff <= csr_wdata;
         end
         if (csr_addr == CSR_CONTAINER_RADIUS) begin
            container_radius_ff <= csr_wdata[LIM_W-1:0];
         end
         if (csr_addr == CSR_BOUND_ENABLE) begin
            bound_enable_ff <= csr_wdata[0];
         end
      end
   end

   assign adv = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = adv;

   vsb_integrate u_integrate (
      .clock            (clock),
      .reset            (reset),
      .adv              (adv),
      .in_valid         (req_chan.valid),
      .in_data          (req_chan.data),
      .dt_squared       (dt_squared_ff),
      .container_radius (container_radius_ff),
      .out_valid        (int_valid),
      .out_side         (int_side)
   );

   // squares of the coordinate magnitudes and of the limit
   always_ff @(posedge clock) begin
      if (reset) begin
         vld3_ff <= 1'b0;
         vld4_ff <= 1'b0;
         vld5_ff <= 1'b0;
         vld6_ff <= 1'b0;
      end else if (adv) begin
         vld3_ff <= int_valid;
         vld4_ff <= vld3_ff;
         vld5_ff <= vld4_ff;
         vld6_ff <= sq_valid;
      end
   end

   always_comb begin
      side5_in = side4_ff;
      side5_in.clamp = bound_enable_ff && (rad4_ff > {2'b00, mm4_ff});
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < AXES; i++) begin
            sq3_ff[i] <= mag32(int_side.pos[i]) * mag32(int_side.pos[i]);
         end
         mm3_ff <= int_side.lim * int_side.lim;
         side3_ff <= int_side;

         // three squares of at most 2^62 each cannot carry out of 64 bits
         rad4_ff <= sq3_ff[0] + sq3_ff[1] + sq3_ff[2];
         mm4_ff <= mm3_ff;
         side4_ff <= side3_ff;

         rad5_ff <= rad4_ff;
         side5_ff <= side5_in;
      end
   end

   vsb_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (vld5_ff),
      .in_rad    (rad5_ff),
      .in_side   (side5_ff),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_side  (sq_side)
   );

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < AXES; i++) begin
            num_ff[i] <= mag32(sq_side.pos[i]) * sq_side.lim;
         end
         den_ff <= sq_root;
         side6_ff <= sq_side;
      end
   end

   vsb_divide u_divide (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (vld6_ff),
      .in_num    (num_ff),
      .in_den    (den_ff),
      .in_side   (side6_ff),
      .out_valid (dv_valid),
      .out_quo   (dv_quo),
      .out_side  (dv_side)
   );

   // restore the sign and pick scaled or unscaled position
   always_comb begin
      coord_type fin [AXES];
      coord_type q;
      for (int i = 0; i < AXES; i++) begin
         q = {1'b0, dv_quo[i]};
         if (dv_side.clamp) begin
            fin[i] = dv_side.pos[i][COORD_W-1] ? -q : q;
         end else begin
            fin[i] = dv_side.pos[i];
         end
      end
      rsp_in.next_x = fin[0];
      rsp_in.next_y = fin[1];
      rsp_in.next_z = fin[2];
      rsp_in.vel_x = dv_side.vel[0];
      rsp_in.vel_y = dv_side.vel[1];
      rsp_in.vel_z = dv_side.vel[2];
      rsp_in.was_clamped = dv_side.clamp;
      rsp_in.saturated = dv_side.sat;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= dv_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_data_ff <= rsp_in;
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.data = rsp_data_ff;

endmodule

FILE: rtl/vsb_integrate.sv
// Two-stage Verlet integration: velocity, acc*dt^2 term, saturated sum.
// Depends on vsb_pkg.
`timescale 1ns / 1ps

module vsb_integrate
   import vsb_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            adv,
   input  logic            in_valid,
   input  req_payload_type in_data,
   input  logic [31:0]     dt_squared,
   input  logic [LIM_W-1:0] container_radius,
   output logic            out_valid,
   output side_type        out_side
);

   coord_type              cur [AXES];
   coord_type              prv [AXES];
   coord_type              acc [AXES];

   // stage 1
   coord_type              vel_in [AXES];
   logic signed [63:0]     prod_in [AXES];
   logic [AXES-1:0]        vsat_in;
   logic [LIM_W-1:0]       lim_in;
   coord_type              cur_ff [AXES];
   coord_type              vel_ff [AXES];
   logic signed [63:0]     prod_ff [AXES];
   logic                   sat1_ff;
   logic [LIM_W-1:0]       lim1_ff;
   logic                   vld1_ff;

   // stage 2
   side_type               side_in;
   side_type               side_ff;
   logic                   vld2_ff;

   assign cur[0] = in_data.cur_x;
   assign cur[1] = in_data.cur_y;
   assign cur[2] = in_data.cur_z;
   assign prv[0] = in_data.prev_x;
   assign prv[1] = in_data.prev_y;
   assign prv[2] = in_data.prev_z;
   assign acc[0] = in_data.acc_x;
   assign acc[1] = in_data.acc_y;
   assign acc[2] = in_data.acc_z;

   always_comb begin
      logic signed [32:0] diff;
      logic signed [64:0] prod;
      for (int i = 0; i < AXES; i++) begin
         diff = {cur[i][31], cur[i]} - {prv[i][31], prv[i]};
         vsat_in[i] = diff[32] != diff[31];
         vel_in[i] = vsat_in[i] ? (diff[32] ? COORD_MIN : COORD_MAX) : diff[31:0];
         prod = acc[i] * $signed({1'b0, dt_squared});
         prod_in[i] = prod[63:0];
      end
      lim_in = (container_radius > in_data.particle_radius) ?
               container_radius - in_data.particle_radius : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
      end else if (adv) begin
         vld1_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         cur_ff <= cur;
         vel_ff <= vel_in;
         prod_ff <= prod_in;
         sat1_ff <= |vsat_in;
         lim1_ff <= lim_in;
      end
   end

   // round to nearest, ties up, then saturate the three-term sum once
   always_comb begin
      logic signed [63:0] rnd;
      logic signed [33:0] sum;
      logic               psat;
      psat = 1'b0;
      side_in = '0;
      for (int i = 0; i < AXES; i++) begin
         rnd = prod_ff[i] + 64'sh0000_0000_8000_0000;
         sum = {{2{cur_ff[i][31]}}, cur_ff[i]} + {{2{vel_ff[i][31]}}, vel_ff[i]} +
               {{2{rnd[63]}}, rnd[63:32]};
         if (sum[33:31] != 3'b000 && sum[33:31] != 3'b111) begin
            psat = 1'b1;
            side_in.pos[i] = sum[33] ? COORD_MIN : COORD_MAX;
         end else begin
            side_in.pos[i] = sum[31:0];
         end
         side_in.vel[i] = vel_ff[i];
      end
      side_in.sat = sat1_ff | psat;
      side_in.clamp = 1'b0;
      side_in.lim = lim1_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld2_ff <= 1'b0;
      end else if (adv) begin
         vld2_ff <= vld1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         side_ff <= side_in;
      end
   end

   assign out_valid = vld2_ff;
   assign out_side = side_ff;

endmodule

FILE: rtl/vsb_sqrt.sv
// Pipelined integer square root of a 64-bit value, one root bit per stage.
// Depends on vsb_pkg.
`timescale 1ns / 1ps

module vsb_sqrt
   import vsb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        adv,
   input  logic        in_valid,
   input  logic [63:0] in_rad,
   input  side_type    in_side,
   output logic        out_valid,
   output logic [31:0] out_root,
   output side_type    out_side
);

   logic [63:0] rad_ff  [SQRT_STAGES];
   logic [33:0] rem_ff  [SQRT_STAGES];
   logic [31:0] root_ff [SQRT_STAGES];
   side_type    side_ff [SQRT_STAGES];
   logic [SQRT_STAGES-1:0] vld_ff;

   for (genvar j = 0; j < SQRT_STAGES; j++) begin : g_stage
      logic [63:0] src_rad;
      logic [33:0] src_rem;
      logic [31:0] src_root;
      side_type    src_side;
      logic        src_vld;
      logic [35:0] t;
      logic [35:0] trial;
      logic        ge;

      if (j == 0) begin : g_first
         assign src_rad = in_rad;
         assign src_rem = '0;
         assign src_root = '0;
         assign src_side = in_side;
         assign src_vld = in_valid;
      end else begin : g_next
         assign src_rad = rad_ff[j-1];
         assign src_rem = rem_ff[j-1];
         assign src_root = root_ff[j-1];
         assign src_side = side_ff[j-1];
         assign src_vld = vld_ff[j-1];
      end

      // bring down the next two bits and try subtracting 4*root+1
      assign t = {src_rem, src_rad[63-2*j -: 2]};
      assign trial = {2'b00, src_root, 2'b01};
      assign ge = t >= trial;

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[j] <= 1'b0;
         end else if (adv) begin
            vld_ff[j] <= src_vld;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rad_ff[j] <= src_rad;
            rem_ff[j] <= ge ? 34'(t - trial) : t[33:0];
            root_ff[j] <= {src_root[30:0], ge};
            side_ff[j] <= src_side;
         end
      end
   end

   assign out_valid = vld_ff[SQRT_STAGES-1];
   assign out_root = root_ff[SQRT_STAGES-1];
   assign out_side = side_ff[SQRT_STAGES-1];

endmodule

FILE: rtl/vsb_divide.sv
// Pipelined restoring divider, three lanes sharing one divisor, one
// quotient bit per stage. Depends on vsb_pkg.
`timescale 1ns / 1ps

module vsb_divide
   import vsb_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             adv,
   input  logic             in_valid,
   input  logic [62:0]      in_num [AXES],
   input  logic [31:0]      in_den,
   input  side_type         in_side,
   output logic             out_valid,
   output logic [LIM_W-1:0] out_quo [AXES],
   output side_type         out_side
);

   logic [62:0]      num_ff [DIV_STAGES][AXES];
   logic [31:0]      rem_ff [DIV_STAGES][AXES];
   logic [LIM_W-1:0] quo_ff [DIV_STAGES][AXES];
   logic [31:0]      den_ff [DIV_STAGES];
   side_type         side_ff [DIV_STAGES];
   logic [DIV_STAGES-1:0] vld_ff;

   for (genvar j = 0; j < DIV_STAGES; j++) begin : g_stage
      logic [62:0]      src_num [AXES];
      logic [31:0]      src_rem [AXES];
      logic [LIM_W-1:0] src_quo [AXES];
      logic [31:0]      src_den;
      side_type         src_side;
      logic             src_vld;
      logic [31:0]      rem_in [AXES];
      logic [LIM_W-1:0] quo_in [AXES];

      if (j == 0) begin : g_first
         // quotient stays below 2^31, so the top half is already below the divisor
         for (genvar l = 0; l < AXES; l++) begin : g_lane
            assign src_num[l] = in_num[l];
            assign src_rem[l] = in_num[l][62:31];
            assign src_quo[l] = '0;
         end
         assign src_den = in_den;
         assign src_side = in_side;
         assign src_vld = in_valid;
      end else begin : g_next
         for (genvar l = 0; l < AXES; l++) begin : g_lane
            assign src_num[l] = num_ff[j-1][l];
            assign src_rem[l] = rem_ff[j-1][l];
            assign src_quo[l] = quo_ff[j-1][l];
         end
         assign src_den = den_ff[j-1];
         assign src_side = side_ff[j-1];
         assign src_vld = vld_ff[j-1];
      end

      always_comb begin
         logic [32:0] t;
         logic        ge;
         for (int l = 0; l < AXES; l++) begin
            t = {src_rem[l], src_num[l][30-j]};
            ge = t >= {1'b0, src_den};
            rem_in[l] = ge ? 32'(t - {1'b0, src_den}) : t[31:0];
            quo_in[l] = src_quo[l];
            quo_in[l][30-j] = ge;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[j] <= 1'b0;
         end else if (adv) begin
            vld_ff[j] <= src_vld;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            num_ff[j] <= src_num;
            rem_ff[j] <= rem_in;
            quo_ff[j] <= quo_in;
            den_ff[j] <= src_den;
            side_ff[j] <= src_side;
         end
      end
   end

   assign out_valid = vld_ff[DIV_STAGES-1];
   assign out_quo = quo_ff[DIV_STAGES-1];
   assign out_side = side_ff[DIV_STAGES-1];

endmodule

FILE: rtl/vsb_checker.sv
// Port-level checks on the Verlet step block, bound to its top level.
// Depends on vsb_pkg and verlet_step_with_sphere_bound_macros.svh.
`timescale 1ns / 1ps
`include "verlet_step_with_sphere_bound_macros.svh"

module vsb_checker
   import vsb_pkg::*;
(
   input logic            clock,
   input logic            reset,
   input logic            req_ready,
   input logic            rsp_valid,
   input logic            rsp_ready,
   input rsp_payload_type rsp_data
);

   // input side is open exactly when the output register can move
   `VSB_ASSERT(a_ready_follows_output, clock, reset, req_ready == (!rsp_valid || rsp_ready), "req ready does not track output register")

   `VSB_ASSERT_ALWAYS(a_reset_empties, clock, $past(reset) |-> !rsp_valid, "result valid right after reset")

   `VSB_ASSERT(a_rsp_valid_holds, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid, "result dropped while stalled")

   `VSB_ASSERT(a_rsp_data_holds, clock, reset, rsp_valid && !rsp_ready |=> $stable(rsp_data), "result changed while stalled")

endmodule

bind verlet_step_with_sphere_bound vsb_checker u_vsb_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_data  (rsp_chan.data)
);

FILE: bench/tb_top.sv
// Self-checking bench for the Verlet step with sphere bound: drives particles over
// the request channel, predicts or looks up each result, checks it field by field.
// Depends on vsb_pkg, vsb_chan_if and verlet_step_with_sphere_bound.
`timescale 1ns / 1ps

module tb_top
   import vsb_pkg::*;
();

   localparam int unsigned CLK_HALF = 4;
   localparam int unsigned LATENCY = 70;
   localparam int unsigned STALL_MAX = 17;
   localparam int unsigned LONG_HOLD = 600;
   localparam int unsigned IDLE_LIMIT = 4000;
   localparam int unsigned ITEMS_PER_PHASE = 220;
   localparam logic [1:0] CSR_UNUSED = 2'd3;
   localparam longint S32_HI = 64'sd2147483647;
   localparam longint S32_LO = -64'sd2147483648;

   typedef struct {
      req_payload_type req;
      bit              bound_on;
      bit              typed;
      rsp_payload_type rsp;
   } particle_row_type;

   logic        clock;
   logic        reset;
   logic        csr_we;
   logic [1:0]  csr_addr;
   logic [31:0] csr_wdata;

   vsb_chan_if #(.payload_type(req_payload_type)) req_if ();
   vsb_chan_if #(.payload_type(rsp_payload_type)) rsp_if ();

   verlet_step_with_sphere_bound i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_if.sink),
      .rsp_chan  (rsp_if.source),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata)
   );

   // Configuration as the block should hold it.
   logic [31:0]      dt_sq;
   logic [LIM_W-1:0] box_radius;
   logic             bound_on;

   rsp_payload_type next_pos_q[$];
   int unsigned     mismatch_cnt = 0;
   int unsigned     sent_cnt = 0;
   int unsigned     clamp_cnt = 0;
   int unsigned     sat_cnt = 0;
   bit              hold_rsp_long = 0;
   bit              sender_quiet = 0;

   initial begin
      clock = 0;
      forever #(CLK_HALF) clock = ~clock;
   end

   function automatic longint clip32(input longint v, inout bit hit);
      if (v > S32_HI) begin
         hit = 1;
         return S32_HI;
      end
      if (v < S32_LO) begin
         hit = 1;
         return S32_LO;
      end
      return v;
   endfunction

   function automatic longint unsigned int_sqrt(input longint unsigned s);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > s) b >>= 2;
      while (b != 0) begin
         if (s >= r + b) begin
            s -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   function automatic rsp_payload_type verlet_predict(input req_payload_type r);
      longint          c[3], p[3], a[3], v[3], pos[3], term;
      longint unsigned m, s, d, mag;
      bit              sat, clamp;
      rsp_payload_type o;
      sat = 0;
      clamp = 0;
      c = '{r.cur_x, r.cur_y, r.cur_z};
      p = '{r.prev_x, r.prev_y, r.prev_z};
      a = '{r.acc_x, r.acc_y, r.acc_z};
      for (int i = 0; i < 3; i++) begin
         v[i] = clip32(c[i] - p[i], sat);
         // round to nearest, ties up
         term = (a[i] * longint'({32'd0, dt_sq}) + 64'sd2147483648) >>> 32;
         pos[i] = clip32(c[i] + v[i] + term, sat);
      end
      if (bound_on) begin
         m = (box_radius > r.particle_radius) ? box_radius - r.particle_radius : 0;
         s = 0;
         for (int i = 0; i < 3; i++) begin
            mag = (pos[i] < 0) ? -pos[i] : pos[i];
            s += mag * mag;
         end
         if (s > m * m) begin
            d = int_sqrt(s);
            if (d == 0) d = 1;
            clamp = 1;
            for (int i = 0; i < 3; i++) begin
               mag = (pos[i] < 0) ? -pos[i] : pos[i];
               pos[i] = (pos[i] < 0) ? -longint'((mag * m) / d) : longint'((mag * m) / d);
            end
         end
      end
      o.next_x = pos[0][31:0];
      o.next_y = pos[1][31:0];
      o.next_z = pos[2][31:0];
      o.vel_x = v[0][31:0];
      o.vel_y = v[1][31:0];
      o.vel_z = v[2][31:0];
      o.was_clamped = clamp;
      o.saturated = sat;
      return o;
   endfunction

   function automatic req_payload_type particle(
      input coord_type cx, cy, cz, px, py, pz, ax, ay, az,
      input logic [LIM_W-1:0] prad);
      req_payload_type r;
      r = '{cx, cy, cz, px, py, pz, ax, ay, az, prad};
      return r;
   endfunction

   function automatic req_payload_type random_particle();
      req_payload_type r;
      coord_type       c[3], p[3], a[3];
      if ($urandom_range(0, 9) < 2) begin
         r = {$urandom, $urandom, $urandom, $urandom, $urandom,
              $urandom, $urandom, $urandom, $urandom, LIM_W'($urandom)};
      end else begin
         // particle inside a few hundred units, slow, moderate acceleration
         for (int i = 0; i < 3; i++) begin
            c[i] = $signed($urandom_range(0, 32'h01FF_FFFF)) - 32'sh0100_0000;
            p[i] = c[i] + $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
            a[i] = $signed($urandom_range(0, 32'h0FFF_FFFF)) - 32'sh0800_0000;
         end
         r = particle(c[0], c[1], c[2], p[0], p[1], p[2], a[0], a[1], a[2],
                      LIM_W'($urandom_range(0, 20 << FRAC_BITS)));
      end
      return r;
   endfunction

   function automatic int unsigned draw_gap(input bit quiet);
      if (quiet || $urandom_range(0, 3) == 0) return 0;
      return $urandom_range(0, STALL_MAX);
   endfunction

   task automatic write_csr(input logic [1:0] idx, input logic [31:0] value);
      csr_we = 1;
      csr_addr = idx;
      csr_wdata = value;
      @(negedge clock);
      csr_we = 0;
      unique case (idx)
         CSR_DT_SQUARED:       dt_sq = value;
         CSR_CONTAINER_RADIUS: box_radius = value[LIM_W-1:0];
         CSR_BOUND_ENABLE:     bound_on = value[0];
         default: ;
      endcase
   endtask

   // Hold the sender until every result is back, then let the pipe settle.
   task automatic drain();
      while (next_pos_q.size() != 0) @(negedge clock);
      repeat (LATENCY + 10) @(negedge clock);
   endtask

   // Offer one item; returns at the falling edge after it is taken.
   task automatic send_particle(input req_payload_type r, input bit typed,
                                input rsp_payload_type want);
      int unsigned gap;
      gap = draw_gap(sender_quiet);
      if (gap > 0) begin
         req_if.valid = 0;
         repeat (gap) @(negedge clock);
      end
      req_if.valid = 1;
      req_if.data = r;
      do @(posedge clock); while (!req_if.ready);
      next_pos_q.push_back(typed ? want : verlet_predict(r));
      sent_cnt++;
      @(negedge clock);
   endtask

   task automatic run_random(input int unsigned n);
      rsp_payload_type none;
      int unsigned     burst;
      none = '0;
      burst = 0;
      for (int unsigned k = 0; k < n; k++) begin
         if (burst == 0 && $urandom_range(0, 39) == 0) burst = $urandom_range(10, 40);
         sender_quiet = (burst != 0);
         if (burst != 0) burst--;
         send_particle(random_particle(), 0, none);
      end
      sender_quiet = 0;
      req_if.valid = 0;
   endtask

   // Result side: random stalls, quiet bursts, one long hold when asked.
   initial begin
      int unsigned n, burst;
      burst = 0;
      rsp_if.ready = 0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_rsp_long) begin
            n = LONG_HOLD;
            hold_rsp_long = 0;
         end else begin
            if (burst == 0 && $urandom_range(0, 39) == 0) burst = $urandom_range(10, 40);
            n = draw_gap(burst != 0);
            if (burst != 0) burst--;
         end
         if (n > 0) begin
            rsp_if.ready = 0;
            repeat (n) @(negedge clock);
         end
         rsp_if.ready = 1;
         do @(posedge clock); while (!rsp_if.valid);
         @(negedge clock);
      end
   end

   task automatic check_coord(input string fname, input logic [31:0] want, got);
      if (want !== got) begin
         $display("%0t: %s expected %h actual %h", $realtime, fname, want, got);
         mismatch_cnt++;
      end
   endtask

   always @(posedge clock) begin
      rsp_payload_type want, got;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got = rsp_if.data;
         if (next_pos_q.size() == 0) begin
            $display("%0t: unexpected item %h", $realtime, got);
            mismatch_cnt++;
         end else begin
            want = next_pos_q.pop_front();
            check_coord("next_x", want.next_x, got.next_x);
            check_coord("next_y", want.next_y, got.next_y);
            check_coord("next_z", want.next_z, got.next_z);
            check_coord("vel_x", want.vel_x, got.vel_x);
            check_coord("vel_y", want.vel_y, got.vel_y);
            check_coord("vel_z", want.vel_z, got.vel_z);
            check_coord("was_clamped", {31'd0, want.was_clamped}, {31'd0, got.was_clamped});
            check_coord("saturated", {31'd0, want.saturated}, {31'd0, got.saturated});
            clamp_cnt += got.was_clamped;
            sat_cnt += got.saturated;
         end
      end
   end

   // Watchdog on cycles with no item moving.
   always @(posedge clock) begin
      int unsigned idle;
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         idle = 0;
      end else begin
         idle++;
         if (idle == IDLE_LIMIT) begin
            $display("%0t: no progress, %0d items outstanding", $realtime, next_pos_q.size());
            $display("Mismatches found");
            $finish;
         end
      end
   end

   initial begin
      particle_row_type rows[$];
      coord_type        hi, lo, ten, hundred;
      rsp_payload_type  zero_rsp;
      hi = COORD_MAX;
      lo = COORD_MIN;
      ten = 32'sd10 <<< FRAC_BITS;
      hundred = 32'sd100 <<< FRAC_BITS;
      zero_rsp = '0;

      reset = 1;
      csr_we = 0;
      csr_addr = CSR_DT_SQUARED;
      csr_wdata = '0;
      req_if.valid = 0;
      req_if.data = '0;
      dt_sq = DT_SQ_RESET;
      box_radius = RADIUS_RESET;
      bound_on = 1;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 0;

      rows.push_back('{particle(0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, 1, zero_rsp});
      rows.push_back('{particle(hi, hi, hi, lo, lo, lo, 0, 0, 0, 0), 0, 1,
                       '{hi, hi, hi, hi, hi, hi, 1'b0, 1'b1}});
      rows.push_back('{particle(lo, lo, lo, hi, hi, hi, 0, 0, 0, 0), 0, 1,
                       '{lo, lo, lo, lo, lo, lo, 1'b0, 1'b1}});
      rows.push_back('{particle(hi, lo, hi, lo, hi, lo, hi, lo, hi, '1), 0, 0, zero_rsp});
      rows.push_back('{particle(hi, hi, hi, lo, lo, lo, 0, 0, 0, 0), 1, 0, zero_rsp});
      rows.push_back('{particle(lo, hi, lo, hi, lo, hi, 0, 0, 0, 0), 1, 0, zero_rsp});
      // limit clamped at zero: particle bigger than the container
      rows.push_back('{particle(ten, 0, 0, ten, 0, 0, 0, 0, 0, '1), 1, 1,
                       '{32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 1'b1, 1'b0}});
      // exactly on the sphere stays put
      rows.push_back('{particle(hundred, 0, 0, hundred, 0, 0, 0, 0, 0, 0), 1, 1,
                       '{hundred, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 1'b0, 1'b0}});
      rows.push_back('{particle(hundred + 1, 0, 0, hundred, 0, 0, 0, 0, 0, 0), 1, 0, zero_rsp});
      rows.push_back('{particle(-hundred, -hundred, ten, -hundred, -ten, 0, 0, 0, 0, 1),
                       1, 0, zero_rsp});
      rows.push_back('{particle(0, 0, 0, 0, 0, 0, hi, hi, hi, 0), 1, 0, zero_rsp});
      rows.push_back('{particle(0, 0, 0, 0, 0, 0, lo, lo, lo, 0), 1, 0, zero_rsp});
      rows.push_back('{particle(0, 0, 0, 0, 0, 0, -1, 1, 32'sh8000, 0), 0, 0, zero_rsp});
      rows.push_back('{particle(ten, -ten, ten, 0, 0, 0, 0, 0, 0, ten), 1, 0, zero_rsp});

      foreach (rows[i]) begin
         if (rows[i].bound_on != bound_on) begin
            req_if.valid = 0;
            drain();
            write_csr(CSR_BOUND_ENABLE, {31'd0, rows[i].bound_on});
         end
         send_particle(rows[i].req, rows[i].typed, rows[i].rsp);
      end
      req_if.valid = 0;
      drain();
      write_csr(CSR_BOUND_ENABLE, 32'd1);
      run_random(ITEMS_PER_PHASE);

      drain();
      write_csr(CSR_DT_SQUARED, 32'd0);
      write_csr(CSR_CONTAINER_RADIUS, 32'd0);
      run_random(ITEMS_PER_PHASE / 2);

      drain();
      write_csr(CSR_DT_SQUARED, 32'hFFFF_FFFF);
      write_csr(CSR_CONTAINER_RADIUS, 32'hFFFF_FFFF);
      run_random(ITEMS_PER_PHASE);

      drain();
      write_csr(CSR_BOUND_ENABLE, 32'hFFFF_FFFE);
      write_csr(CSR_DT_SQUARED, $urandom);
      run_random(ITEMS_PER_PHASE);

      drain();
      write_csr(CSR_BOUND_ENABLE, 32'd1);
      write_csr(CSR_CONTAINER_RADIUS, 32'd50 << FRAC_BITS);
      write_csr(CSR_UNUSED, $urandom);
      write_csr(CSR_DT_SQUARED, 32'h0100_0000);
      run_random(ITEMS_PER_PHASE);

      // fill the pipe against a long result stall
      drain();
      write_csr(CSR_CONTAINER_RADIUS, $urandom_range(0, 200 << FRAC_BITS));
      write_csr(CSR_DT_SQUARED, DT_SQ_RESET);
      hold_rsp_long = 1;
      sender_quiet = 1;
      for (int k = 0; k < 150; k++) send_particle(random_particle(), 0, zero_rsp);
      req_if.valid = 0;
      run_random(ITEMS_PER_PHASE / 2);

      drain();
      $display("Ran %0d particles over six register settings, bound on and off,", sent_cnt);
      $display("%0d results pulled onto the sphere, %0d saturated.", clamp_cnt, sat_cnt);
      if (mismatch_cnt == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end
endmodule
